>>> rtl/srcp_pkg.sv
// shared types and constants for the s-record character parser
`timescale 1ns / 1ps

package srcp_pkg;

	// parser phase within one record line
	typedef enum logic [2:0] {
		PH_SKIP = 3'd0,
		PH_TYPE = 3'd1,
		PH_LEN  = 3'd2,
		PH_AHI  = 3'd3,
		PH_ALO  = 3'd4,
		PH_DATA = 3'd5
	} phase_t;

	// result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// record types
	localparam logic [1:0] REC_S0 = 2'd0;
	localparam logic [1:0] REC_S1 = 2'd1;
	localparam logic [1:0] REC_S9 = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_HEADER = 3'd1;
	localparam logic [2:0] ERR_LENGTH = 3'd2;
	localparam logic [2:0] ERR_TYPE   = 3'd3;
	localparam logic [2:0] ERR_HEX    = 3'd4;

	// characters
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] SUM_GOOD = 8'hFF;
	localparam logic [7:0] LEN_MIN  = 8'd3;
	localparam logic [7:0] LEN_RESET = 8'hFF;

	// one result word
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  rec_type;
		logic [15:0] address;
		logic [7:0]  data_byte;
		logic        checksum_ok;
		logic [2:0]  error_code;
	} result_t;

endpackage

>>> rtl/srecord_char_parser_top.sv
// top level of the s-record character parser
`timescale 1ns / 1ps

// channel   dir  tdata                         tuser
// s_*       in   ch                            line_start
// m_*       out  rec_type, address, data_byte,  out_kind
//                checksum_ok, error_code
// cfg_*     in   max_record_length (write only)
//
// one character word per cycle sustained while the result queue is not full; a result
// passes the input register, then the parse into the queue, before it leaves
// all parse state sits in one register set updated once per character
// reset: parser skips to the next line start, length limit returns to 255
// an output stall is absorbed by a two-entry result queue; the input side
// only stops once the queue is full and a character is waiting

module srecord_char_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// input characters
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic [0:0]  s_tuser,   // [0] line_start
	// parse results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [1:0] rec_type, [17:2] address, [25:18] data_byte,
	                               // [26] checksum_ok, [29:27] error_code, [31:30] zero
	output logic [1:0]  m_tuser,   // [1:0] out_kind
	// length limit register
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);
	import srcp_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       start_s1;
	logic [7:0] max_len_q;
	logic       fifo_full;
	logic       fire;
	logic       s_accept;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	// input register can refill whenever its word moves on
	assign fire     = valid_s1 && !fifo_full;
	assign s_tready = !valid_s1 || !fifo_full;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// character payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_accept) begin
			ch_s1    <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	// length limit; it must be written only while idle (the block does not enforce this)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	srcp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.ch        (ch_s1),
		.line_start(start_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	srcp_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.full     (fifo_full),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_res)
	);

	// output word packing
	assign m_tuser = out_res.kind;
	assign m_tdata = {2'b00, out_res.error_code, out_res.checksum_ok, out_res.data_byte,
	                  out_res.address, out_res.rec_type};

endmodule

>>> rtl/srcp_core.sv
// record parser state and per-character decode
`timescale 1ns / 1ps

module srcp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           ch,
	input  logic                 line_start,
	input  logic [7:0]           max_len,
	output logic                 res_valid,
	output srcp_pkg::result_t    res
);
	import srcp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  type_q, type_d;
	logic        type_bad_q, type_bad_d;
	logic [3:0]  hi_nib_q, hi_nib_d;
	logic        pend_q, pend_d;
	logic [7:0]  left_q, left_d;
	logic [15:0] cur_addr_q, cur_addr_d;
	logic [15:0] rec_addr_q, rec_addr_d;
	logic [7:0]  sum_q, sum_d;

	logic        is_hex;
	logic [3:0]  nib;
	logic [7:0]  byte_val;
	logic [7:0]  sum_new;
	logic        in_hex_phase;
	logic        len_bad;

	// hex digit decode
	always_comb begin
		is_hex = 1'b1;
		nib    = '0;
		if (ch >= CH_0 && ch <= CH_9) begin
			nib = 4'(ch - CH_0);
		end else if (ch >= CH_UA && ch <= CH_UF) begin
			nib = 4'(ch - CH_UA + 8'd10);
		end else if (ch >= CH_LA && ch <= CH_LF) begin
			nib = 4'(ch - CH_LA + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign byte_val     = {hi_nib_q, nib};
	assign sum_new      = sum_q + byte_val;
	assign in_hex_phase = (phase_q == PH_LEN) || (phase_q == PH_AHI) ||
	                      (phase_q == PH_ALO) || (phase_q == PH_DATA);
	assign len_bad      = (byte_val > max_len) || (byte_val < LEN_MIN);

	// next state
	always_comb begin
		phase_d    = phase_q;
		type_d     = type_q;
		type_bad_d = type_bad_q;
		hi_nib_d   = hi_nib_q;
		pend_d     = pend_q;
		left_d     = left_q;
		cur_addr_d = cur_addr_q;
		rec_addr_d = rec_addr_q;
		sum_d      = sum_q;
		if (line_start) begin
			type_d     = REC_S0;
			type_bad_d = 1'b0;
			pend_d     = 1'b0;
			hi_nib_d   = '0;
			left_d     = '0;
			sum_d      = '0;
			phase_d    = (ch == CH_S) ? PH_TYPE : PH_SKIP;
		end else if (phase_q == PH_TYPE) begin
			phase_d = PH_LEN;
			if (ch == CH_0) begin
				type_d = REC_S0;
			end else if (ch == CH_1) begin
				type_d = REC_S1;
			end else if (ch == CH_9) begin
				type_d = REC_S9;
			end else begin
				type_d     = REC_S0;
				type_bad_d = 1'b1;
			end
		end else if (in_hex_phase) begin
			if (!is_hex) begin
				phase_d = PH_SKIP;
				pend_d  = 1'b0;
			end else if (!pend_q) begin
				hi_nib_d = nib;
				pend_d   = 1'b1;
			end else begin
				pend_d = 1'b0;
				sum_d  = sum_new;
				case (phase_q)
					PH_LEN: begin
						if (len_bad || type_bad_q) begin
							phase_d = PH_SKIP;
						end else begin
							left_d  = byte_val;
							phase_d = PH_AHI;
						end
					end
					PH_AHI: begin
						rec_addr_d = {byte_val, 8'h00};
						left_d     = left_q - 8'd1;
						phase_d    = PH_ALO;
					end
					PH_ALO: begin
						rec_addr_d = {rec_addr_q[15:8], byte_val};
						cur_addr_d = {rec_addr_q[15:8], byte_val};
						left_d     = left_q - 8'd1;
						phase_d    = PH_DATA;
					end
					default: begin
						if (left_q <= 8'd1) begin
							left_d  = '0;
							phase_d = PH_SKIP;
						end else begin
							left_d = left_q - 8'd1;
							if (type_q != REC_S9) begin
								cur_addr_d = cur_addr_q + 16'd1;
							end
						end
					end
				endcase
			end
		end
	end

	// result
	always_comb begin
		res_valid       = 1'b0;
		res.kind        = KIND_ERR;
		res.rec_type    = type_bad_q ? REC_S0 : type_q;
		res.address     = '0;
		res.data_byte   = '0;
		res.checksum_ok = 1'b0;
		res.error_code  = ERR_NONE;
		if (line_start) begin
			if (ch != CH_S) begin
				res_valid      = 1'b1;
				res.rec_type   = REC_S0;
				res.error_code = ERR_HEADER;
			end
		end else if (in_hex_phase) begin
			if (!is_hex) begin
				res_valid      = 1'b1;
				res.error_code = ERR_HEX;
			end else if (pend_q) begin
				case (phase_q)
					PH_LEN: begin
						if (len_bad) begin
							res_valid      = 1'b1;
							res.error_code = ERR_LENGTH;
						end else if (type_bad_q) begin
							res_valid      = 1'b1;
							res.error_code = ERR_TYPE;
						end
					end
					PH_DATA: begin
						if (left_q <= 8'd1) begin
							res_valid       = 1'b1;
							res.kind        = KIND_END;
							res.rec_type    = type_q;
							res.address     = rec_addr_q;
							res.checksum_ok = (sum_new == SUM_GOOD);
						end else if (type_q != REC_S9) begin
							res_valid     = 1'b1;
							res.kind      = KIND_DATA;
							res.rec_type  = type_q;
							res.address   = cur_addr_q;
							res.data_byte = byte_val;
						end
					end
					default: begin
						res_valid = 1'b0;
					end
				endcase
			end
		end
		if (!fire) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SKIP;
			type_q     <= REC_S0;
			type_bad_q <= 1'b0;
			hi_nib_q   <= '0;
			pend_q     <= 1'b0;
			left_q     <= '0;
			cur_addr_q <= '0;
			rec_addr_q <= '0;
			sum_q      <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			type_q     <= type_d;
			type_bad_q <= type_bad_d;
			hi_nib_q   <= hi_nib_d;
			pend_q     <= pend_d;
			left_q     <= left_d;
			cur_addr_q <= cur_addr_d;
			rec_addr_q <= rec_addr_d;
			sum_q      <= sum_d;
		end
	end

endmodule

>>> rtl/srcp_out_fifo.sv
// two-entry result queue that decouples the parser from the output stall
`timescale 1ns / 1ps

module srcp_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  srcp_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output srcp_pkg::result_t out_data
);
	import srcp_pkg::*;

	result_t    mem_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/srcp_checker.sv
// port-level checks for the s-record character parser, bound to the top level
`timescale 1ns / 1ps

module srcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import srcp_pkg::*;

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// error words carry a code and no address, data or checksum flag
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_ERR) |->
			(m_tdata[29:27] != ERR_NONE) && (m_tdata[26:2] == '0))
		else $error("malformed error word");

	// data and end words never carry an error code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == KIND_DATA) || (m_tuser == KIND_END)) |->
			(m_tdata[29:27] == ERR_NONE))
		else $error("error code on a non-error word");

	// s9 records never emit data bytes, and data words carry no checksum flag
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_DATA) |->
			(m_tdata[1:0] != REC_S9) && !m_tdata[26])
		else $error("bad data word");

	// the input side keeps taking words while the output is drained
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_tready) && m_tready |-> s_tready)
		else $error("input stalled with output flowing");

endmodule

bind srecord_char_parser_top srcp_checker u_srcp_checker (.*);

>>> tb/tb_srecord_char_parser_top.sv
// self-checking testbench for the s-record character parser top level
`timescale 1ns / 1ps

module tb_srecord_char_parser_top;
	import srcp_pkg::*;

	localparam int N_DIRECTED      = 26;
	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int HOLD_CYCLES     = 150;   // long output stall, fills the result queue
	localparam int SETTLE_CYCLES   = 6;     // lets a result pass the input register and the queue
	localparam int WATCHDOG_LIMIT  = 1000;  // cycles with no handshake on either side
	localparam int PRINT_LIMIT     = 30;

	// one character word as it travels on the input stream
	typedef struct packed {
		logic [7:0] c;
		logic       ls;
	} char_word_t;

	// directed row: the result is typed in unless by_model is set
	typedef struct packed {
		logic [7:0] c;
		logic       ls;
		logic       by_model;
		logic       has_res;
		result_t    res;
	} directed_row_t;

	localparam result_t NIL = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;

	srecord_char_parser_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// parser state as predicted from the accepted characters
	phase_t      parse_phase = PH_SKIP;
	logic [1:0]  held_type = REC_S0;
	logic        type_invalid = 1'b0;
	logic [3:0]  upper_nibble = '0;
	logic        nibble_waiting = 1'b0;
	logic [7:0]  bytes_remaining = '0;
	logic [15:0] next_address = '0;
	logic [15:0] line_address = '0;
	logic [7:0]  byte_sum = '0;
	logic [7:0]  len_limit = LEN_RESET;

	result_t     pending_results[$];
	char_word_t  line_words[$];
	int          mismatches = 0;
	int          results_seen = 0;

	// hand-checked opening sequence
	directed_row_t directed_plan [N_DIRECTED] = '{
		// ignored until the first line start
		'{8'h5A, 1'b0, 1'b0, 1'b0, NIL},
		// header extremes, both not 'S'
		'{8'h00, 1'b1, 1'b0, 1'b1, '{KIND_ERR, REC_S0, 16'h0000, 8'h00, 1'b0, ERR_HEADER}},
		'{8'hFF, 1'b1, 1'b0, 1'b1, '{KIND_ERR, REC_S0, 16'h0000, 8'h00, 1'b0, ERR_HEADER}},
		// bad type 'X' reported only once the length byte 03 passes
		'{CH_S,  1'b1, 1'b0, 1'b0, NIL},
		'{8'h58, 1'b0, 1'b0, 1'b0, NIL},
		'{CH_0,  1'b0, 1'b0, 1'b0, NIL},
		'{8'h33, 1'b0, 1'b0, 1'b1, '{KIND_ERR, REC_S0, 16'h0000, 8'h00, 1'b0, ERR_TYPE}},
		// S9 with length 02, below the minimum
		'{CH_S,  1'b1, 1'b0, 1'b0, NIL},
		'{CH_9,  1'b0, 1'b0, 1'b0, NIL},
		'{CH_0,  1'b0, 1'b0, 1'b0, NIL},
		'{8'h32, 1'b0, 1'b0, 1'b1, '{KIND_ERR, REC_S9, 16'h0000, 8'h00, 1'b0, ERR_LENGTH}},
		// S1 with 'g' where the length should start
		'{CH_S,  1'b1, 1'b0, 1'b0, NIL},
		'{CH_1,  1'b0, 1'b0, 1'b0, NIL},
		'{8'h67, 1'b0, 1'b0, 1'b1, '{KIND_ERR, REC_S1, 16'h0000, 8'h00, 1'b0, ERR_HEX}},
		// S1 04 FFff Ab 52: one data byte at the top address, good checksum
		'{CH_S,  1'b1, 1'b0, 1'b0, NIL},
		'{CH_1,  1'b0, 1'b0, 1'b0, NIL},
		'{CH_0,  1'b0, 1'b0, 1'b0, NIL},
		'{8'h34, 1'b0, 1'b0, 1'b0, NIL},
		'{CH_UF, 1'b0, 1'b0, 1'b0, NIL},
		'{CH_UF, 1'b0, 1'b0, 1'b0, NIL},
		'{CH_LF, 1'b0, 1'b0, 1'b0, NIL},
		'{CH_LF, 1'b0, 1'b0, 1'b0, NIL},
		'{CH_UA, 1'b0, 1'b0, 1'b0, NIL},
		'{8'h62, 1'b0, 1'b1, 1'b0, NIL},
		'{8'h35, 1'b0, 1'b0, 1'b0, NIL},
		'{8'h32, 1'b0, 1'b0, 1'b1, '{KIND_END, REC_S1, 16'hFFFF, 8'h00, 1'b1, ERR_NONE}}
	};

	function automatic int hex_digit(logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
		if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
		if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
		return -1;
	endfunction

	// error result: abandon the line, type reads as S0 once known bad
	function automatic bit flag_error(logic [2:0] code, output result_t r);
		parse_phase = PH_SKIP;
		nibble_waiting = 1'b0;
		r = '0;
		r.kind = KIND_ERR;
		r.rec_type = type_invalid ? REC_S0 : held_type;
		r.error_code = code;
		return 1'b1;
	endfunction

	// advances the predicted parser by one character, returns 1 with a result
	function automatic bit parse_char(logic [7:0] c, logic ls, output result_t r);
		int         v;
		logic [7:0] b;
		r = '0;
		if (ls) begin
			held_type = REC_S0;
			type_invalid = 1'b0;
			nibble_waiting = 1'b0;
			upper_nibble = '0;
			bytes_remaining = '0;
			byte_sum = '0;
			if (c != CH_S) return flag_error(ERR_HEADER, r);
			parse_phase = PH_TYPE;
			return 1'b0;
		end
		if (parse_phase == PH_TYPE) begin
			case (c)
				CH_0: held_type = REC_S0;
				CH_1: held_type = REC_S1;
				CH_9: held_type = REC_S9;
				default: begin
					held_type = REC_S0;
					type_invalid = 1'b1;
				end
			endcase
			parse_phase = PH_LEN;
			return 1'b0;
		end
		if (parse_phase == PH_SKIP) return 1'b0;
		v = hex_digit(c);
		if (v < 0) return flag_error(ERR_HEX, r);
		if (!nibble_waiting) begin
			upper_nibble = v[3:0];
			nibble_waiting = 1'b1;
			return 1'b0;
		end
		nibble_waiting = 1'b0;
		b = {upper_nibble, v[3:0]};
		byte_sum = byte_sum + b;
		case (parse_phase)
			PH_LEN: begin
				if (b > len_limit || b < LEN_MIN) return flag_error(ERR_LENGTH, r);
				if (type_invalid) return flag_error(ERR_TYPE, r);
				bytes_remaining = b;
				parse_phase = PH_AHI;
				return 1'b0;
			end
			PH_AHI: begin
				line_address = {b, 8'h00};
				bytes_remaining = bytes_remaining - 8'd1;
				parse_phase = PH_ALO;
				return 1'b0;
			end
			PH_ALO: begin
				line_address[7:0] = b;
				next_address = line_address;
				bytes_remaining = bytes_remaining - 8'd1;
				parse_phase = PH_DATA;
				return 1'b0;
			end
			default: begin
				// checksum byte closes the record
				if (bytes_remaining <= 8'd1) begin
					bytes_remaining = '0;
					parse_phase = PH_SKIP;
					r.kind = KIND_END;
					r.rec_type = held_type;
					r.address = line_address;
					r.checksum_ok = (byte_sum == SUM_GOOD);
					return 1'b1;
				end
				bytes_remaining = bytes_remaining - 8'd1;
				// S9 payload is summed but never emitted
				if (held_type == REC_S9) return 1'b0;
				r.kind = KIND_DATA;
				r.rec_type = held_type;
				r.address = next_address;
				r.data_byte = b;
				next_address = next_address + 16'd1;
				return 1'b1;
			end
		endcase
	endfunction

	// two hex characters, letters in random case
	function automatic void push_hex_byte(logic [7:0] b);
		logic [3:0] n;
		logic [7:0] c;
		for (int i = 1; i >= 0; i--) begin
			n = b[i*4 +: 4];
			if (n < 4'd10) c = CH_0 + 8'(n);
			else c = ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(n - 4'd10);
			line_words.push_back(char_word_t'{c, 1'b0});
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("result %0d: %s got 0x%0h, expected 0x%0h", results_seen, what, got, want);
	endtask

	// offer one word after a gap, predict once it is taken
	task automatic send_char(char_word_t w, int gap, output bit got, output result_t r);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = w.c;
		s_tuser = w.ls;
		do @(posedge clk); while (!s_tready);
		got = parse_char(w.c, w.ls, r);
	endtask

	// stop offering, let every expected word drain and the pipeline empty
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls with stretches of none, two long holds
	initial begin : result_sink
		int      stall;
		int      run_left;
		bit      steady;
		result_t got;
		result_t want;
		run_left = 0;
		steady = 1'b0;
		wait (arst_n);
		forever begin
			if (run_left == 0) begin
				steady = ($urandom_range(0, 2) == 0);
				run_left = $urandom_range(8, 40);
			end
			run_left--;
			stall = steady ? 0 : $urandom_range(0, 7);
			if (results_seen == 60 || results_seen == 600) stall = HOLD_CYCLES;
			repeat (stall) begin
				@(negedge clk);
				m_tready = 1'b0;
			end
			@(negedge clk);
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.kind = m_tuser;
			got.rec_type = m_tdata[1:0];
			got.address = m_tdata[17:2];
			got.data_byte = m_tdata[25:18];
			got.checksum_ok = m_tdata[26];
			got.error_code = m_tdata[29:27];
			if (pending_results.size() == 0) begin
				report_mismatch("word with nothing pending, out_kind", got.kind, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.kind != want.kind)
					report_mismatch("out_kind", got.kind, want.kind);
				if (got.rec_type != want.rec_type)
					report_mismatch("rec_type", got.rec_type, want.rec_type);
				if (got.address != want.address)
					report_mismatch("address", got.address, want.address);
				if (got.data_byte != want.data_byte)
					report_mismatch("data_byte", got.data_byte, want.data_byte);
				if (got.checksum_ok != want.checksum_ok)
					report_mismatch("checksum_ok", got.checksum_ok, want.checksum_ok);
				if (got.error_code != want.error_code)
					report_mismatch("error_code", got.error_code, want.error_code);
			end
			results_seen++;
		end
	end

	// any stretch without a handshake on either side ends the run
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("timeout: no handshake for %0d cycles, %0d results pending",
			WATCHDOG_LIMIT, pending_results.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin : char_source
		logic [7:0]  limit_plan [N_PHASES];
		logic [7:0]  hdr;
		logic [7:0]  tc;
		logic [7:0]  sum;
		logic [7:0]  db;
		logic [15:0] addr;
		result_t     r;
		bit          got;
		bit          steady;
		int          phase_items;
		int          first;
		int          len;
		int          lim;
		int          roll;
		int          n_data;
		int          idx;
		int          cut;

		// extremes first, then short and one random limit
		limit_plan = '{8'd255, 8'd20, 8'd3, 8'd0, 8'd4, 8'd9, 8'd255, 8'd12};
		limit_plan[5] = 8'($urandom_range(5, 60));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows at the reset length limit
		foreach (directed_plan[i]) begin
			send_char(char_word_t'{directed_plan[i].c, directed_plan[i].ls},
				$urandom_range(0, 7), got, r);
			if (!directed_plan[i].by_model) begin
				got = directed_plan[i].has_res;
				r = directed_plan[i].res;
			end
			if (got) pending_results.push_back(r);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			@(negedge clk);
			cfg_wr_en = 1'b1;
			cfg_wr_data = limit_plan[p];
			@(negedge clk);
			cfg_wr_en = 1'b0;
			len_limit = limit_plan[p];

			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				line_words.delete();
				// stray characters between lines
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 3))
						line_words.push_back(char_word_t'{8'($urandom), 1'b0});
				first = line_words.size();

				hdr = ($urandom_range(0, 19) == 0) ? 8'($urandom) : CH_S;
				line_words.push_back(char_word_t'{hdr, 1'b1});
				roll = $urandom_range(0, 99);
				if (roll < 40) tc = CH_1;
				else if (roll < 60) tc = CH_0;
				else if (roll < 85) tc = CH_9;
				else tc = 8'($urandom);
				line_words.push_back(char_word_t'{tc, 1'b0});

				// mostly short legal lengths, sometimes the limit itself or just outside
				lim = int'(len_limit);
				roll = $urandom_range(0, 99);
				if (roll < 3) len = $urandom_range(0, 255);
				else if (roll < 6) len = (lim == 255) ? 2 : lim + 1;
				else if (roll < 8 && lim >= 3) len = lim;
				else if (lim >= 3) len = $urandom_range(3, (lim > 20) ? 20 : lim);
				else len = $urandom_range(0, 8);

				addr = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
					: 16'($urandom);
				sum = 8'(len) + addr[15:8] + addr[7:0];
				push_hex_byte(8'(len));
				push_hex_byte(addr[15:8]);
				push_hex_byte(addr[7:0]);
				n_data = (len >= 3) ? len - 3 : $urandom_range(0, 2);
				repeat (n_data) begin
					db = 8'($urandom);
					sum = sum + db;
					push_hex_byte(db);
				end
				push_hex_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : ~sum);

				// occasional garbled character or cut-off line
				if ($urandom_range(0, 11) == 0) begin
					idx = $urandom_range(first + 1, line_words.size() - 1);
					line_words[idx].c = 8'($urandom);
				end
				if ($urandom_range(0, 15) == 0) begin
					cut = $urandom_range(first + 1, line_words.size() - 1);
					while (line_words.size() > cut) void'(line_words.pop_back());
				end
				phase_items += line_words.size() - first;
				if ($urandom_range(0, 4) == 0) begin
					line_words.push_back(char_word_t'{8'h0D, 1'b0});
					line_words.push_back(char_word_t'{8'h0A, 1'b0});
				end

				steady = ($urandom_range(0, 4) == 0);
				foreach (line_words[i]) begin
					send_char(line_words[i], steady ? 0 : $urandom_range(0, 7), got, r);
					if (got) pending_results.push_back(r);
				end
			end
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
